FILE: rtl/core/eos_pkg.sv
package eos_pkg;

   localparam int TABLE_RES_DEFAULT      = 64;
   localparam int MATERIAL_SLOTS_DEFAULT = 6;
   localparam int FRAC_BITS_DEFAULT      = 16;
   localparam int SLOT_DEPTH             = 4096;
   localparam int ADDR_BITS              = 12;
   localparam int WORD_BITS              = 32;

   typedef enum logic [1:0] {
      OP_WRITE_TABLE = 2'd0,
      OP_WRITE_RANGE = 2'd1,
      OP_SAMPLE      = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] c0;
      logic signed [WORD_BITS-1:0] c1;
      logic signed [WORD_BITS-1:0] c2;
      logic signed [WORD_BITS-1:0] c3;
   } quad_type;

   // log2(1 + i/256) in Q0.16 by repeated squaring on a Q2.30 value
   function automatic logic [15:0] mant_log(input logic [7:0] idx);
      logic [63:0] y;
      logic [15:0] r;
      y = ({56'd0, idx} + 64'd256) << 22;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
         y = (y * y) >> 30;
         if (y >= (64'd2 << 30)) begin
            r[b] = 1'b1;
            y = y >> 1;
         end
      end
      return r;
   endfunction

   typedef logic [15:0] rom_type [256];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = mant_log(8'(i));
      end
      return t;
   endfunction

   localparam rom_type MANT_LOG_ROM = build_rom();

endpackage

FILE: rtl/core/eos_coord.sv
// log2 of a float and its scaled, clamped coordinate; three register stages
module eos_coord #(
   parameter int FRAC_BITS = eos_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [31:0]         bits_in,
   input  logic signed [31:0]  lmin,
   input  logic signed [31:0]  inv,
   output logic [FRAC_BITS:0]  coord
);
   localparam int UP   = FRAC_BITS >= 16 ? FRAC_BITS - 16 : 0;
   localparam int DOWN = FRAC_BITS >= 16 ? 0 : 16 - FRAC_BITS;
   localparam logic signed [47:0] LOG_MAX = 48'sd8388607;
   localparam logic signed [47:0] LOG_MIN = -48'sd8257536;

   logic signed [47:0] l_in, l_ff;
   logic signed [31:0] inv_ff;
   logic signed [31:0] lmin_ff;
   logic               zero_in, zero_ff;
   logic [63:0]        prod_in, prod_ff;
   logic [FRAC_BITS:0] coord_in, coord_ff;
   logic signed [48:0] d;
   logic [48:0]        md;
   logic [31:0]        mi;
   logic [7:0]         e;
   logic signed [47:0] lraw;
   logic [63:0]        q;

   always_comb begin
      e = bits_in[30:23];
      if (e == 8'hff) begin
         lraw = LOG_MAX;
      end else if (bits_in[31] || e == 8'd0) begin
         lraw = LOG_MIN;
      end else begin
         lraw = ((48'(e) - 48'sd127) <<< 16)
            + 48'(eos_pkg::MANT_LOG_ROM[bits_in[22:15]]);
      end
      l_in = (lraw <<< UP) >>> DOWN;
   end

   always_comb begin
      d = 49'(l_ff) - 49'(lmin_ff);
      md = d[48] ? 49'(-d) : 49'(d);
      mi = inv_ff[31] ? 32'(-inv_ff) : 32'(inv_ff);
      zero_in = (d == 0) || (inv_ff == 0) || (d[48] != inv_ff[31]);
      prod_in = 64'(md) * 64'(mi);
   end

   always_comb begin
      q = prod_ff >> FRAC_BITS;
      if (zero_ff) begin
         coord_in = '0;
      end else if (q >= (64'd1 << FRAC_BITS)) begin
         coord_in = (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
         coord_in = q[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         l_ff     <= l_in;
         inv_ff   <= inv;
         lmin_ff  <= lmin;
         zero_ff  <= zero_in;
         prod_ff  <= prod_in;
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;
endmodule

FILE: rtl/core/eos_table_bilinear_lookup_unit.sv
// Equation-of-state lookup unit. Beats with operation 0 load one four-channel
// entry of a material's table, operation 1 loads a material's range entry;
// neither gives a response. Operation 2 samples: log2 of energy and density,
// scaled into 0..1, bilinear interpolation over the four nearest entries,
// one response beat. Unknown slots answer 0, 1.0, 0 and the density itself.
// One beat is accepted every cycle unless a waiting response is stalled; a
// sample's response passes through nine register stages: three for log2 and
// the coordinates, one for the index multiply, one for the corner addresses,
// one for the read address, the table read and two blend stages. Table writes
// ride the same pipe and land in the table at the read stage, so a sample
// sees exactly the writes that came before it. The table is kept as four full
// copies, one per corner, each with one write and one read port, so four
// reads occur in each cycle that the pipe advances. Entries must be written
// before they are sampled.
module eos_table_bilinear_lookup_unit #(
   parameter int TABLE_RES      = eos_pkg::TABLE_RES_DEFAULT,
   parameter int MATERIAL_SLOTS = eos_pkg::MATERIAL_SLOTS_DEFAULT,
   parameter int FRAC_BITS      = eos_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [2:0]          req_material,
   input  logic [11:0]         req_entry_address,
   input  logic signed [31:0]  req_word_a,
   input  logic signed [31:0]  req_word_b,
   input  logic signed [31:0]  req_word_c,
   input  logic signed [31:0]  req_word_d,
   input  logic [31:0]         req_energy_bits,
   input  logic [31:0]         req_density_bits,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pressure_out,
   output logic signed [31:0]  rsp_sound_speed_out,
   output logic signed [31:0]  rsp_temperature_out,
   output logic signed [31:0]  rsp_density_out
);
   localparam int DEPTH  = MATERIAL_SLOTS * eos_pkg::SLOT_DEPTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int MB     = 3;
   localparam int LAT    = 9;
   localparam int WR_LAT = 6;

   // pipeline moves whenever the output is free or taken
   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic acc;
   assign acc = req_valid && adv;

   // range store is small, read at one address
   eos_pkg::quad_type range_ff [MATERIAL_SLOTS];
   eos_pkg::quad_type rng;
   logic known;
   assign known = 32'(req_material) < MATERIAL_SLOTS;
   assign rng = known ? range_ff[req_material[MB-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (acc && known && req_operation == eos_pkg::OP_WRITE_RANGE) begin
         range_ff[req_material[MB-1:0]] <=
            '{req_word_a, req_word_b, req_word_c, req_word_d};
      end
   end

   // float to fixed for unknown slot density
   function automatic logic signed [31:0] to_fixed(input logic [31:0] b);
      logic [7:0]  e;
      logic [63:0] m, mag;
      int          s;
      e = b[30:23];
      m = (e == 0) ? 64'(b[22:0]) : 64'({1'b1, b[22:0]});
      s = ((e == 0) ? 1 : int'(e)) - 150 + FRAC_BITS;
      if (s >= 0) mag = (s > 31) ? (64'd1 << 40) : (m << s);
      else mag = (-s >= 64) ? 64'd0 : (m >> (-s));
      if (e == 8'hff) return (b[22:0] != 0) ? 32'sd0 :
         (b[31] ? 32'sh80000000 : 32'sh7fffffff);
      if (m == 0) return 32'sd0;
      if (b[31]) return (mag >= 64'h80000000) ? 32'sh80000000 : -32'(mag);
      return (mag > 64'h7fffffff) ? 32'sh7fffffff : 32'(mag);
   endfunction

   // side band carried down the pipe
   typedef struct packed {
      logic              sample;
      logic              known;
      logic [MB-1:0]     mat;
      logic signed [31:0] dens;
   } side_type;

   logic     v_ff [LAT];
   side_type s_ff [LAT];
   side_type s_in;
   assign s_in = '{sample: req_operation == eos_pkg::OP_SAMPLE, known: known,
                   mat: req_material, dens: to_fixed(req_density_bits)};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= acc && req_operation == eos_pkg::OP_SAMPLE;
         for (int i = 1; i < LAT; i++) v_ff[i] <= v_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0] <= s_in;
         for (int i = 1; i < LAT; i++) s_ff[i] <= s_ff[i-1];
      end
   end

   // stages 0..2: coordinates
   logic [FRAC_BITS:0] cu, cv;
   eos_coord #(.FRAC_BITS(FRAC_BITS)) u_cu (
      .clock(clock), .enable(adv), .bits_in(req_energy_bits),
      .lmin(rng.c0), .inv(rng.c1), .coord(cu));
   eos_coord #(.FRAC_BITS(FRAC_BITS)) u_cv (
      .clock(clock), .enable(adv), .bits_in(req_density_bits),
      .lmin(rng.c2), .inv(rng.c3), .coord(cv));

   // stage 3: scale by resolution
   logic [FRAC_BITS+9:0] x_ff, y_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= (FRAC_BITS+10)'(cu) * (FRAC_BITS+10)'(TABLE_RES - 1);
         y_ff <= (FRAC_BITS+10)'(cv) * (FRAC_BITS+10)'(TABLE_RES - 1);
      end
   end

   // stage 4: corner addresses
   logic [9:0] x0, y0, x1, y1;
   assign x0 = x_ff[FRAC_BITS+9:FRAC_BITS];
   assign y0 = y_ff[FRAC_BITS+9:FRAC_BITS];
   assign x1 = (32'(x0) + 1 < TABLE_RES) ? x0 + 10'd1 : 10'(TABLE_RES - 1);
   assign y1 = (32'(y0) + 1 < TABLE_RES) ? y0 + 10'd1 : 10'(TABLE_RES - 1);

   logic [11:0] a_ff [4];
   logic [FRAC_BITS-1:0] tx_ff [3], ty_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= 12'(32'(y0) * TABLE_RES + 32'(x0));
         a_ff[1] <= 12'(32'(y0) * TABLE_RES + 32'(x1));
         a_ff[2] <= 12'(32'(y1) * TABLE_RES + 32'(x0));
         a_ff[3] <= 12'(32'(y1) * TABLE_RES + 32'(x1));
         tx_ff[0] <= x_ff[FRAC_BITS-1:0];
         ty_ff[0] <= y_ff[FRAC_BITS-1:0];
         for (int i = 1; i < 3; i++) tx_ff[i] <= tx_ff[i-1];
         for (int i = 1; i < 4; i++) ty_ff[i] <= ty_ff[i-1];
      end
   end

   // table writes travel with the pipe and land at the read stage, in beat order
   logic [AW-1:0] waddr;
   assign waddr = AW'(32'(req_material) * eos_pkg::SLOT_DEPTH
                      + 32'(req_entry_address));
   logic wr;
   assign wr = acc && known && req_operation == eos_pkg::OP_WRITE_TABLE;

   logic              wr_ff    [WR_LAT];
   logic [AW-1:0]     waddr_ff [WR_LAT];
   eos_pkg::quad_type wdata_ff [WR_LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WR_LAT; i++) wr_ff[i] <= 1'b0;
      end else if (adv) begin
         wr_ff[0] <= wr;
         for (int i = 1; i < WR_LAT; i++) wr_ff[i] <= wr_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         waddr_ff[0] <= waddr;
         wdata_ff[0] <= '{req_word_a, req_word_b, req_word_c, req_word_d};
         for (int i = 1; i < WR_LAT; i++) begin
            waddr_ff[i] <= waddr_ff[i-1];
            wdata_ff[i] <= wdata_ff[i-1];
         end
      end
   end

   // stage 5: read address; stage 6: table read, one copy per corner
   eos_pkg::quad_type corner [4];
   logic [MB-1:0] rmat;
   assign rmat = s_ff[4].mat;

   for (genvar g = 0; g < 4; g++) begin : g_bank
      eos_pkg::quad_type mem [DEPTH];
      logic [AW-1:0] raddr_ff;
      always_ff @(posedge clock) begin
         if (adv) raddr_ff <= AW'(32'(rmat) * eos_pkg::SLOT_DEPTH + 32'(a_ff[g]));
      end
      always_ff @(posedge clock) begin
         if (adv && wr_ff[WR_LAT-1]) begin
            mem[waddr_ff[WR_LAT-1]] <= wdata_ff[WR_LAT-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) corner[g] <= mem[raddr_ff];
      end
   end

   function automatic logic signed [31:0] ch(input eos_pkg::quad_type q,
                                              input int k);
      case (k)
         0:       return q.c0;
         1:       return q.c1;
         2:       return q.c2;
         default: return q.c3;
      endcase
   endfunction

   // stages 7..8: blend along x, then along y
   logic signed [47:0] lo_ff [4], hi_ff [4];
   logic signed [31:0] res_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            lo_ff[k] <= 48'((81'(ch(corner[0], k)) * 81'((1 << FRAC_BITS) - tx_ff[2])
                       + 81'(ch(corner[1], k)) * 81'(tx_ff[2])) >>> FRAC_BITS);
            hi_ff[k] <= 48'((81'(ch(corner[2], k)) * 81'((1 << FRAC_BITS) - tx_ff[2])
                       + 81'(ch(corner[3], k)) * 81'(tx_ff[2])) >>> FRAC_BITS);
            res_ff[k] <= 32'((96'(lo_ff[k]) * 96'((1 << FRAC_BITS) - ty_ff[3])
                        + 96'(hi_ff[k]) * 96'(ty_ff[3])) >>> FRAC_BITS);
         end
      end
   end

   // output
   assign rsp_valid = v_ff[LAT-1];
   always_comb begin
      if (s_ff[LAT-1].known) begin
         rsp_pressure_out    = res_ff[0];
         rsp_sound_speed_out = res_ff[1];
         rsp_temperature_out = res_ff[2];
         rsp_density_out     = res_ff[3];
      end else begin
         rsp_pressure_out    = '0;
         rsp_sound_speed_out = 32'(1) << FRAC_BITS;
         rsp_temperature_out = '0;
         rsp_density_out     = s_ff[LAT-1].dens;
      end
   end

   // a held response keeps its beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_density_out))
      else $error("response lost under stall");
   // stall only comes from the response side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("spurious request stall");
   // only samples reach the output
   a_samp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> s_ff[LAT-1].sample)
      else $error("write produced a response");
endmodule
